FILE: rtl/core/pdnc_pkg.sv
// pdnc_pkg: shared types, codes and helpers for the percent decode name check
// used by pdnc_decode, pdnc_out_queue and percent_decode_name_check_unit
`default_nettype none

package pdnc_pkg;

    localparam int PDNC_COUNT_WIDTH = 10;
    localparam int LIMIT_WIDTH      = 10;
    localparam int LENGTH_WIDTH     = 10;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_PTR_WIDTH  = 2;
    localparam int QUEUE_CNT_WIDTH  = 3;

    localparam logic [LIMIT_WIDTH-1:0]  MAX_ENC_RESET = 10'd765;
    localparam logic [LIMIT_WIDTH-1:0]  MAX_DEC_RESET = 10'd255;
    localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX    = 10'd1023;

    localparam logic [7:0] CHAR_PERCENT   = 8'h25;
    localparam logic [7:0] CHAR_DOT       = 8'h2e;
    localparam logic [7:0] CHAR_SLASH     = 8'h2f;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_DEL       = 8'h7f;

    typedef enum logic [0:0] {
        REG_MAX_ENC = 1'b0,
        REG_MAX_DEC = 1'b1
    } t_reg_index;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_PCT  = 2'd1,
        ESC_HIGH = 2'd2
    } t_esc_phase;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_LENGTH   = 2'd1,
        ST_BAD_ENCODING = 2'd2,
        ST_UNSAFE       = 2'd3
    } t_status;

    typedef struct packed {
        logic                    is_status;
        logic [7:0]              out_byte;
        t_status                 status_code;
        logic [LENGTH_WIDTH-1:0] decoded_length;
        logic                    out_last;
    } t_result;

    // {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/percent_decode_name_check_unit.sv
// percent_decode_name_check_unit: top level of the percent decode name check
// depends on pdnc_pkg, pdnc_decode and pdnc_out_queue
//
// Usage:
//   Input channel i_valid/o_ready carries one encoded name byte per request
//   (i_in_byte) with i_in_last on the final byte. Output channel
//   o_valid/i_ready carries result requests: a decoded byte item for every
//   completed byte, and one status item (o_is_status, o_out_last high) after
//   the last byte. A last byte that completes a decoded byte gives two items.
//   Results enter the result queue at the edge that accepts their byte. A byte
//   is taken every cycle while o_ready is high; the four-entry result queue
//   absorbs the extra result of a last byte that gives two results. The queue
//   sets the rate: o_ready is high while at least two entries are free, so
//   bytes keep flowing while a result waits to be taken. When the receiver
//   stalls, up to four results are held and input stops. Reset (synchronous,
//   active low) clears all name state and the queue and loads the length
//   limits 765 and 255. Limits are written through i_cfg_we/i_cfg_index/
//   i_cfg_data by the user only while idle; the block does not enforce it.
`default_nettype none

module percent_decode_name_check_unit
    import pdnc_pkg::*;
#(
    parameter int COUNT_WIDTH = PDNC_COUNT_WIDTH
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_index,
    input  wire logic [LIMIT_WIDTH-1:0]  i_cfg_data,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [7:0]              i_in_byte,
    input  wire logic                    i_in_last,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic                         o_is_status,
    output logic [7:0]                   o_out_byte,
    output logic [1:0]                   o_status_code,
    output logic [LENGTH_WIDTH-1:0]      o_decoded_length,
    output logic                         o_out_last
);

    logic [LIMIT_WIDTH-1:0] r_max_enc;
    logic [LIMIT_WIDTH-1:0] r_max_dec;
    logic                   take;
    t_result                item0, item1, out_item;
    logic [1:0]             num;
    logic [1:0]             push_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_enc <= MAX_ENC_RESET;
            r_max_dec <= MAX_DEC_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_MAX_ENC: r_max_enc <= i_cfg_data;
                REG_MAX_DEC: r_max_dec <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign take     = i_valid && o_ready;
    assign push_num = take ? num : 2'd0;

    pdnc_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .i_max_enc (r_max_enc),
        .i_max_dec (r_max_dec),
        .o_item0   (item0),
        .o_item1   (item1),
        .o_num     (num)
    );

    pdnc_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_num (push_num),
        .i_item0    (item0),
        .i_item1    (item1),
        .o_space    (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (out_item)
    );

    assign o_is_status      = out_item.is_status;
    assign o_out_byte       = out_item.out_byte;
    assign o_status_code    = out_item.status_code;
    assign o_decoded_length = out_item.decoded_length;
    assign o_out_last       = out_item.out_last;

endmodule

`default_nettype wire

FILE: rtl/core/pdnc_decode.sv
// pdnc_decode: per-name escape decoder, counters, safety flags and status
// depends on pdnc_pkg
`default_nettype none

module pdnc_decode
    import pdnc_pkg::*;
#(
    parameter int COUNT_WIDTH = PDNC_COUNT_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_take,
    input  wire logic [7:0]             i_in_byte,
    input  wire logic                   i_in_last,
    input  wire logic [LIMIT_WIDTH-1:0] i_max_enc,
    input  wire logic [LIMIT_WIDTH-1:0] i_max_dec,
    output t_result                     o_item0,
    output t_result                     o_item1,
    output logic [1:0]                  o_num
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > LENGTH_WIDTH) ? COUNT_WIDTH : LENGTH_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    t_esc_phase             r_phase, n_phase;
    logic [3:0]             r_high_nibble, n_high_nibble;
    logic [COUNT_WIDTH-1:0] r_enc_count, n_enc_count;
    logic [COUNT_WIDTH-1:0] r_dec_count, n_dec_count;
    logic                   r_enc_err, n_enc_err;
    logic                   r_unsafe, n_unsafe;
    logic                   r_all_dots, n_all_dots;

    logic [4:0]             hex;
    logic                   emit;
    logic [7:0]             dbyte;
    logic [CMP_WIDTH-1:0]   enc_ext;
    logic [CMP_WIDTH-1:0]   dec_ext;
    logic [LENGTH_WIDTH-1:0] dec_len;
    t_status                code;
    t_result                byte_item;
    t_result                status_item;

    always_comb begin
        hex           = hex_value(i_in_byte);
        emit          = 1'b0;
        dbyte         = 8'd0;
        n_high_nibble = r_high_nibble;
        n_enc_err     = r_enc_err;
        n_phase       = ESC_NONE;
        n_enc_count   = (r_enc_count == COUNT_MAX) ? COUNT_MAX : r_enc_count + 1'b1;

        case (r_phase)
            ESC_PCT: begin
                if (hex[4]) begin
                    n_high_nibble = hex[3:0];
                    n_phase       = ESC_HIGH;
                end else begin
                    n_enc_err = 1'b1;
                end
            end
            ESC_HIGH: begin
                if (hex[4]) begin
                    dbyte = {r_high_nibble, hex[3:0]};
                    emit  = 1'b1;
                end else begin
                    n_enc_err = 1'b1;
                end
            end
            default: begin
                if (i_in_byte == CHAR_PERCENT) begin
                    n_phase = ESC_PCT;
                end else begin
                    dbyte = i_in_byte;
                    emit  = 1'b1;
                end
            end
        endcase

        n_dec_count = r_dec_count;
        n_unsafe    = r_unsafe;
        n_all_dots  = r_all_dots;
        if (emit) begin
            n_dec_count = (r_dec_count == COUNT_MAX) ? COUNT_MAX : r_dec_count + 1'b1;
            if (dbyte < CHAR_SPACE || dbyte == CHAR_DEL || dbyte == CHAR_SLASH ||
                dbyte == CHAR_BACKSLASH) begin
                n_unsafe = 1'b1;
            end
            if (dbyte != CHAR_DOT) begin
                n_all_dots = 1'b0;
            end
        end

        enc_ext = CMP_WIDTH'(n_enc_count);
        dec_ext = CMP_WIDTH'(n_dec_count);
        dec_len = (dec_ext > CMP_WIDTH'(LENGTH_MAX)) ? LENGTH_MAX : dec_ext[LENGTH_WIDTH-1:0];

        if (enc_ext > CMP_WIDTH'(i_max_enc)) begin
            code = ST_BAD_LENGTH;
        end else if (n_enc_err || n_phase != ESC_NONE) begin
            code = ST_BAD_ENCODING;
        end else if (n_unsafe || dec_ext == '0 || dec_ext > CMP_WIDTH'(i_max_dec) ||
                     (n_all_dots && dec_ext <= CMP_WIDTH'(2))) begin
            code = ST_UNSAFE;
        end else begin
            code = ST_OK;
        end

        byte_item.is_status        = 1'b0;
        byte_item.out_byte         = dbyte;
        byte_item.status_code      = ST_OK;
        byte_item.decoded_length   = dec_len;
        byte_item.out_last         = 1'b0;

        status_item.is_status      = 1'b1;
        status_item.out_byte       = 8'd0;
        status_item.status_code    = code;
        status_item.decoded_length = dec_len;
        status_item.out_last       = 1'b1;

        o_item0 = emit ? byte_item : status_item;
        o_item1 = status_item;
        o_num   = 2'(emit) + 2'(i_in_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= ESC_NONE;
            r_high_nibble <= 4'd0;
            r_enc_count   <= '0;
            r_dec_count   <= '0;
            r_enc_err     <= 1'b0;
            r_unsafe      <= 1'b0;
            r_all_dots    <= 1'b1;
        end else if (i_take) begin
            if (i_in_last) begin
                // name done, back to a clean slate
                r_phase       <= ESC_NONE;
                r_high_nibble <= 4'd0;
                r_enc_count   <= '0;
                r_dec_count   <= '0;
                r_enc_err     <= 1'b0;
                r_unsafe      <= 1'b0;
                r_all_dots    <= 1'b1;
            end else begin
                r_phase       <= n_phase;
                r_high_nibble <= n_high_nibble;
                r_enc_count   <= n_enc_count;
                r_dec_count   <= n_dec_count;
                r_enc_err     <= n_enc_err;
                r_unsafe      <= n_unsafe;
                r_all_dots    <= n_all_dots;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pdnc_out_queue.sv
// pdnc_out_queue: four-entry result queue taking up to two results per cycle
// depends on pdnc_pkg
`default_nettype none

module pdnc_out_queue
    import pdnc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic [1:0] i_push_num,
    input  wire t_result i_item0,
    input  wire t_result i_item1,
    output logic         o_space,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_item
);

    t_result                    r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_WIDTH-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CNT_WIDTH-1:0] r_count, n_count;
    logic                       pop;
    logic [QUEUE_PTR_WIDTH-1:0] wr_ptr1;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    // room for a worst-case request of two results
    assign o_space = (r_count <= QUEUE_CNT_WIDTH'(QUEUE_DEPTH - 2));
    assign wr_ptr1 = r_wr_ptr + 1'b1;
    assign n_count = r_count + QUEUE_CNT_WIDTH'(i_push_num) - QUEUE_CNT_WIDTH'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QUEUE_PTR_WIDTH'(i_push_num);
            r_rd_ptr <= r_rd_ptr + QUEUE_PTR_WIDTH'(pop);
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_item0;
        end
        if (i_push_num == 2'd2) begin
            r_mem[wr_ptr1] <= i_item1;
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_percent_decode_name_check_unit.sv
// tb_percent_decode_name_check_unit: self-checking bench for the percent decode name check
// drives encoded names through valid/ready, predicts each decoded byte and status item
// depends on pdnc_pkg and percent_decode_name_check_unit
module tb_percent_decode_name_check_unit;
    import pdnc_pkg::*;

    localparam int STALL_LEN       = 80;
    localparam int ITEMS_PER_PHASE = 18;
    localparam int NUM_PHASES      = 7;
    localparam int LONG_PHASE      = 5;
    localparam int LONG_NAME_LEN   = 1030;
    localparam int SETTLE_CYCLES   = 4;
    localparam logic [PDNC_COUNT_WIDTH-1:0] CNT_SAT = '1;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       fixed;
        t_status    code;
    } t_dir_row;

    localparam int DIR_ROWS = 27;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic                    i_cfg_index;
    logic [LIMIT_WIDTH-1:0]  i_cfg_data;
    logic                    i_valid;
    logic                    o_ready;
    logic [7:0]              i_in_byte;
    logic                    i_in_last;
    logic                    o_valid;
    logic                    i_ready;
    logic                    o_is_status;
    logic [7:0]              o_out_byte;
    logic [1:0]              o_status_code;
    logic [LENGTH_WIDTH-1:0] o_decoded_length;
    logic                    o_out_last;

    t_dir_row dir_tab [DIR_ROWS] = '{
        '{"a",    1'b1, 1'b1, ST_OK},
        '{".",    1'b1, 1'b1, ST_UNSAFE},
        '{".",    1'b0, 1'b0, ST_OK},
        '{".",    1'b1, 1'b1, ST_UNSAFE},
        '{"%",    1'b0, 1'b0, ST_OK},
        '{"2",    1'b0, 1'b0, ST_OK},
        '{"E",    1'b1, 1'b1, ST_UNSAFE},
        '{"%",    1'b0, 1'b0, ST_OK},
        '{"4",    1'b0, 1'b0, ST_OK},
        '{"1",    1'b0, 1'b0, ST_OK},
        '{"%",    1'b0, 1'b0, ST_OK},
        '{"6",    1'b0, 1'b0, ST_OK},
        '{"a",    1'b1, 1'b1, ST_OK},
        '{"%",    1'b0, 1'b0, ST_OK},
        '{"g",    1'b0, 1'b0, ST_OK},
        '{"x",    1'b1, 1'b1, ST_BAD_ENCODING},
        '{"%",    1'b0, 1'b0, ST_OK},
        '{"4",    1'b1, 1'b1, ST_BAD_ENCODING},
        '{"%",    1'b0, 1'b0, ST_OK},
        '{"f",    1'b0, 1'b0, ST_OK},
        '{"F",    1'b1, 1'b1, ST_OK},
        '{8'h00,  1'b1, 1'b1, ST_UNSAFE},
        '{8'h7f,  1'b1, 1'b1, ST_UNSAFE},
        '{"/",    1'b1, 1'b1, ST_UNSAFE},
        '{"\\",   1'b1, 1'b1, ST_UNSAFE},
        '{8'hff,  1'b1, 1'b1, ST_OK},
        '{"%",    1'b1, 1'b1, ST_BAD_ENCODING}
    };

    logic [LIMIT_WIDTH-1:0] enc_limits [NUM_PHASES] =
        '{10'd1023, 10'd1, 10'd5, 10'd0, 10'd20, 10'd1023, 10'd765};
    logic [LIMIT_WIDTH-1:0] dec_limits [NUM_PHASES] =
        '{10'd1, 10'd1023, 10'd3, 10'd0, 10'd8, 10'd1023, 10'd255};

    // predictor state
    t_esc_phase                   esc;
    logic [3:0]                   hi_nib;
    logic [PDNC_COUNT_WIDTH-1:0]  enc_cnt;
    logic [PDNC_COUNT_WIDTH-1:0]  dec_cnt;
    logic                         enc_err;
    logic                         unsafe_seen;
    logic                         all_dots;
    logic [LIMIT_WIDTH-1:0]       lim_enc;
    logic [LIMIT_WIDTH-1:0]       lim_dec;

    t_result decoded_due [$];
    int      mismatches = 0;
    int      req_count = 0;
    bit      tx_gaps = 1'b0;
    bit      rx_gaps = 1'b0;
    bit      stall_req = 1'b0;

    percent_decode_name_check_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_in_byte        (i_in_byte),
        .i_in_last        (i_in_last),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_is_status      (o_is_status),
        .o_out_byte       (o_out_byte),
        .o_status_code    (o_status_code),
        .o_decoded_length (o_decoded_length),
        .o_out_last       (o_out_last)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "a" && c <= "f") return int'(c) - 87;
        if (c >= "A" && c <= "F") return int'(c) - 55;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10) return 8'h30 + n;
        return (upper ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    function automatic void clear_name_state();
        esc = ESC_NONE;
        hi_nib = 4'd0;
        enc_cnt = '0;
        dec_cnt = '0;
        enc_err = 1'b0;
        unsafe_seen = 1'b0;
        all_dots = 1'b1;
    endfunction

    function automatic void predict_decode(input logic [7:0] b, input logic last,
                                           input logic fixed, input t_status fixed_code);
        int         h;
        logic       emit;
        logic [7:0] db;
        t_result    r;
        t_status    code;
        emit = 1'b0;
        db = 8'd0;
        if (enc_cnt != CNT_SAT) enc_cnt++;
        case (esc)
            ESC_PCT: begin
                h = hex_digit(b);
                if (h < 0) begin
                    enc_err = 1'b1;
                    esc = ESC_NONE;
                end else begin
                    hi_nib = h[3:0];
                    esc = ESC_HIGH;
                end
            end
            ESC_HIGH: begin
                h = hex_digit(b);
                esc = ESC_NONE;
                if (h < 0) begin
                    enc_err = 1'b1;
                end else begin
                    db = {hi_nib, h[3:0]};
                    emit = 1'b1;
                end
            end
            default: begin
                esc = ESC_NONE;
                if (b == CHAR_PERCENT) begin
                    esc = ESC_PCT;
                end else begin
                    db = b;
                    emit = 1'b1;
                end
            end
        endcase
        if (emit) begin
            if (dec_cnt != CNT_SAT) dec_cnt++;
            if (db < CHAR_SPACE || db == CHAR_DEL || db == CHAR_SLASH || db == CHAR_BACKSLASH)
                unsafe_seen = 1'b1;
            if (db != CHAR_DOT) all_dots = 1'b0;
            r.is_status = 1'b0;
            r.out_byte = db;
            r.status_code = ST_OK;
            r.decoded_length = dec_cnt;
            r.out_last = 1'b0;
            decoded_due.push_back(r);
        end
        if (last) begin
            if (enc_cnt > lim_enc)
                code = ST_BAD_LENGTH;
            else if (enc_err || esc != ESC_NONE)
                code = ST_BAD_ENCODING;
            else if (unsafe_seen || dec_cnt == 0 || dec_cnt > lim_dec ||
                     (all_dots && dec_cnt <= 2))
                code = ST_UNSAFE;
            else
                code = ST_OK;
            if (fixed) code = fixed_code;
            r.is_status = 1'b1;
            r.out_byte = 8'd0;
            r.status_code = code;
            r.decoded_length = dec_cnt;
            r.out_last = 1'b1;
            decoded_due.push_back(r);
            clear_name_state();
        end
    endfunction

    function automatic int pick_gap();
        int v;
        v = $urandom_range(0, 99);
        if (v < 70) return 0;
        if (v < 94) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    task automatic send_req(input logic [7:0] b, input logic last,
                            input logic fixed, input t_status fixed_code);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_decode(b, last, fixed, fixed_code);
        req_count++;
    endtask

    task automatic send_name(ref logic [7:0] nm [$]);
        foreach (nm[i]) send_req(nm[i], i == nm.size() - 1, 1'b0, ST_OK);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (decoded_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [LIMIT_WIDTH-1:0] enc,
                              input logic [LIMIT_WIDTH-1:0] dec);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_MAX_ENC;
        i_cfg_data <= enc;
        @(posedge i_clk);
        i_cfg_index <= REG_MAX_DEC;
        i_cfg_data <= dec;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lim_enc = enc;
        lim_dec = dec;
    endtask

    function automatic void make_name(ref logic [7:0] nm [$]);
        int         len;
        int         kind;
        int         v;
        logic [7:0] c;
        logic [7:0] val;
        nm.delete();
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            // dot-only names, plain or escaped
            len = $urandom_range(1, 3);
            repeat (len) begin
                if ($urandom_range(0, 1)) begin
                    nm.push_back(CHAR_DOT);
                end else begin
                    nm.push_back(CHAR_PERCENT);
                    nm.push_back("2");
                    nm.push_back($urandom_range(0, 1) ? "E" : "e");
                end
            end
            return;
        end
        len = (kind < 12) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        repeat (len) begin
            v = $urandom_range(0, 99);
            if (v < 65) begin
                do c = 8'($urandom_range(32, 126));
                while (c == CHAR_PERCENT || c == CHAR_SLASH || c == CHAR_BACKSLASH);
                nm.push_back(c);
            end else if (v < 80) begin
                val = 8'($urandom_range(0, 255));
                nm.push_back(CHAR_PERCENT);
                nm.push_back(hex_char(val[7:4], 1'($urandom_range(0, 1))));
                nm.push_back(hex_char(val[3:0], 1'($urandom_range(0, 1))));
            end else if (v < 86) begin
                case ($urandom_range(0, 3))
                    0: nm.push_back(8'($urandom_range(0, 31)));
                    1: nm.push_back(CHAR_DEL);
                    2: nm.push_back(CHAR_SLASH);
                    default: nm.push_back(CHAR_BACKSLASH);
                endcase
            end else if (v < 92) begin
                nm.push_back(CHAR_PERCENT);
                if ($urandom_range(0, 1))
                    nm.push_back(hex_char(4'($urandom_range(0, 15)),
                                          1'($urandom_range(0, 1))));
                do c = 8'($urandom_range(0, 255));
                while (hex_digit(c) >= 0);
                nm.push_back(c);
            end else begin
                nm.push_back(8'($urandom_range(0, 255)));
            end
        end
        // cut-off escape at the end
        if ($urandom_range(0, 19) == 0) begin
            nm.push_back(CHAR_PERCENT);
            if ($urandom_range(0, 1))
                nm.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        end
    endfunction

    // receiver: random stalls plus one long hold-off on request
    initial begin : rx_drive
        int idle_left;
        idle_left = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                stall_req = 1'b0;
                idle_left = STALL_LEN;
            end else if (idle_left == 0 && rx_gaps) begin
                idle_left = pick_gap();
            end
            i_ready <= (idle_left == 0);
            if (idle_left > 0) idle_left--;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (decoded_due.size() == 0) begin
                report_mismatch($sformatf("result with none expected: status=%0b byte=%0h",
                                          o_is_status, o_out_byte));
            end else begin
                want = decoded_due.pop_front();
                if (o_is_status !== want.is_status)
                    report_mismatch($sformatf("is_status %0b, expected %0b",
                                              o_is_status, want.is_status));
                if (o_out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %0h, expected %0h",
                                              o_out_byte, want.out_byte));
                if (o_status_code !== want.status_code)
                    report_mismatch($sformatf("status_code %0d, expected %0d",
                                              o_status_code, want.status_code));
                if (o_decoded_length !== want.decoded_length)
                    report_mismatch($sformatf("decoded_length %0d, expected %0d",
                                              o_decoded_length, want.decoded_length));
                if (o_out_last !== want.out_last)
                    report_mismatch($sformatf("out_last %0b, expected %0b",
                                              o_out_last, want.out_last));
            end
        end
    end

    initial begin : run_limit
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] nm [$];
        int         phase_start;
        bit         stalled;
        bit         paused;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in_byte = 8'd0;
        i_in_last = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_MAX_ENC;
        i_cfg_data = '0;
        lim_enc = MAX_ENC_RESET;
        lim_dec = MAX_DEC_RESET;
        clear_name_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows on reset limits
        for (int k = 0; k < DIR_ROWS; k++)
            send_req(dir_tab[k].ch, dir_tab[k].last, dir_tab[k].fixed, dir_tab[k].code);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            set_limits(enc_limits[p], dec_limits[p]);
            tx_gaps = (p % 3 != 0);
            rx_gaps = (p % 3 != 1);
            phase_start = req_count;
            stalled = 1'b0;
            paused = 1'b0;
            while (req_count - phase_start < ITEMS_PER_PHASE) begin
                make_name(nm);
                send_name(nm);
                if (!stalled && req_count - phase_start > ITEMS_PER_PHASE / 4) begin
                    stall_req = 1'b1;
                    stalled = 1'b1;
                end
                if (!paused && req_count - phase_start > ITEMS_PER_PHASE / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
            // long name drives both counts into saturation
            if (p == LONG_PHASE) begin
                nm.delete();
                repeat (LONG_NAME_LEN) nm.push_back(8'($urandom_range(8'h61, 8'h7a)));
                send_name(nm);
            end
        end

        i_valid <= 1'b0;
        while (decoded_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
